// File: hdl/lodfc_pkg.sv
// Shared types, codes and helpers of the lamp ownership, delay and fault controller.
package lodfc_pkg;

  localparam int unsigned Channels = 16;

  localparam logic [6:0] DUTY_FULL = 7'd100;

  localparam int unsigned N1_SELF_BIT = 9;
  localparam int unsigned N1_POSN_BIT = 5;

  // configuration register indexes
  localparam logic [2:0] CFG_SHARED_MODE   = 3'd0;
  localparam logic [2:0] CFG_HIGH_SIDE     = 3'd1;
  localparam logic [2:0] CFG_POSITION_DUTY = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_MASK  = 3'd3;
  localparam logic [2:0] CFG_MATRIX_MASK   = 3'd4;
  localparam logic [2:0] CFG_DELAY_TIMES   = 3'd5;
  localparam logic [2:0] CFG_ON_RAMPS      = 3'd6;
  localparam logic [2:0] CFG_OFF_RAMPS     = 3'd7;

  // shared mode codes
  localparam logic [1:0] MODE_ALONE = 2'd0;
  localparam logic [1:0] MODE_LB    = 2'd1;
  localparam logic [1:0] MODE_POS   = 2'd2;

  // owner codes
  localparam logic [1:0] OWN_SELF = 2'd0;
  localparam logic [1:0] OWN_LB   = 2'd1;
  localparam logic [1:0] OWN_POS  = 2'd2;

  // run phase codes on the result
  localparam logic [1:0] RUN_CODE = 2'd0;
  localparam logic [1:0] ON_CODE  = 2'd1;
  localparam logic [1:0] OFF_CODE = 2'd2;

  // feedback codes
  localparam logic [1:0] FB_OFF   = 2'd0;
  localparam logic [1:0] FB_ON    = 2'd1;
  localparam logic [1:0] FB_ERROR = 2'd2;
  localparam logic [1:0] FB_HOLD  = 2'd3;

  // high-side error state codes
  localparam logic [1:0] HS_NORMAL  = 2'd0;
  localparam logic [1:0] HS_RUNTIME = 2'd1;
  localparam logic [1:0] HS_STORED  = 2'd2;

  typedef enum logic [2:0] {
    PH_RUN = 3'b001,
    PH_ON  = 3'b010,
    PH_OFF = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]          shared_mode;
    logic [1:0]          high_side_channel;
    logic [6:0]          position_duty;
    logic [Channels-1:0] channel_mask;
    logic [Channels-1:0] matrix_mask;
    logic [47:0]         delay_times;
    logic [47:0]         on_ramp_times;
    logic [47:0]         off_ramp_times;
  } cfg_t;

  typedef struct packed {
    logic                lamp_request;
    logic                low_beam_request;
    logic                position_request;
    logic [7:0]          tick_time;
    logic [4:0]          derate_flags;
    logic [Channels-1:0] stored_fault_channels;
    logic [Channels-1:0] live_fault_channels;
    logic [Channels-1:0] sensor_fault_channels;
    logic [15:0]         n1_strategy_bits;
    logic [1:0]          switch_error_state;
  } item_t;

  typedef struct packed {
    logic [1:0]          owner;
    logic [5:0]          history;
    logic [6:0]          cur_target;
    phase_e              phase;
    logic [Channels-1:0] plain_mask;
    logic [Channels-1:0] matrix_mask;
    logic [7:0]          on_delay;
    logic [7:0]          off_delay;
    logic                req_last;
    logic [15:0]         on_ramp_cnt;
    logic [15:0]         off_ramp_cnt;
    logic                lb_on;
    logic [6:0]          posn_duty;
  } state_t;

  typedef struct packed {
    logic [1:0]          owner;
    logic [6:0]          target_duty;
    logic [1:0]          run_phase;
    logic [Channels-1:0] plain_drive_mask;
    logic [Channels-1:0] matrix_drive_mask;
    logic [Channels-1:0] cut_mask;
    logic                drive_update;
    logic                switch_on;
    logic [15:0]         on_ramp;
    logic [15:0]         off_ramp;
    logic [1:0]          feedback;
  } result_t;

  // 16-bit ramp field of an owner
  function automatic logic [15:0] ramp_sel(input logic [47:0] times, input logic [1:0] own);
    logic [15:0] r;
    r = times[15:0];
    unique case (own)
      OWN_LB:  r = times[31:16];
      OWN_POS: r = times[47:32];
      default: r = times[15:0];
    endcase
    return r;
  endfunction

  // on (off = 0) or off (off = 1) delay byte of an owner
  function automatic logic [7:0] delay_sel(input logic [47:0] times, input logic [1:0] own,
                                           input logic off);
    logic [7:0] d;
    d = off ? times[15:8] : times[7:0];
    unique case (own)
      OWN_LB:  d = off ? times[31:24] : times[23:16];
      OWN_POS: d = off ? times[47:40] : times[39:32];
      default: d = off ? times[15:8] : times[7:0];
    endcase
    return d;
  endfunction

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] c;
    c = RUN_CODE;
    unique case (ph)
      PH_ON:   c = ON_CODE;
      PH_OFF:  c = OFF_CODE;
      default: c = RUN_CODE;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/lodfc_cfg.sv
// Configuration register file of the lamp controller.
module lodfc_cfg
  import lodfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  input  logic [2:0]  wr_index_i,
  input  logic [47:0] wr_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        CFG_SHARED_MODE:   cfg_d.shared_mode       = wr_data_i[1:0];
        CFG_HIGH_SIDE:     cfg_d.high_side_channel = wr_data_i[1:0];
        CFG_POSITION_DUTY: cfg_d.position_duty     = wr_data_i[6:0];
        CFG_CHANNEL_MASK:  cfg_d.channel_mask      = wr_data_i[Channels-1:0];
        CFG_MATRIX_MASK:   cfg_d.matrix_mask       = wr_data_i[Channels-1:0];
        CFG_DELAY_TIMES:   cfg_d.delay_times       = wr_data_i;
        CFG_ON_RAMPS:      cfg_d.on_ramp_times     = wr_data_i;
        CFG_OFF_RAMPS:     cfg_d.off_ramp_times    = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/lodfc_step.sv
// Per-tick update: ownership, target, phase timers, fault masking and feedback.
module lodfc_step
  import lodfc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  st_i,
  input  item_t   item_i,
  output state_t  st_o,
  output result_t res_o
);

  logic [Channels-1:0] chn, mtx, ep, em, cut;
  logic                o_last, o_cur, s_last, s_cur, skip, upd, sw, tactic, err;
  logic [6:0]          prev_tgt, pos_sat;
  logic [8:0]          dly_sum;
  logic [16:0]         ramp_sum;
  logic [1:0]          fb;
  state_t              s;

  always_comb begin
    chn      = cfg_i.channel_mask;
    mtx      = cfg_i.matrix_mask;
    s        = st_i;
    cut      = '0;
    upd      = 1'b0;
    sw       = 1'b0;
    fb       = FB_HOLD;
    skip     = 1'b0;
    ep       = '0;
    em       = '0;
    o_last   = 1'b0;
    o_cur    = 1'b0;
    s_last   = st_i.history[0];
    s_cur    = item_i.lamp_request;
    tactic   = 1'b0;
    err      = 1'b0;
    prev_tgt = st_i.cur_target;
    pos_sat  = (cfg_i.position_duty > DUTY_FULL) ? DUTY_FULL : cfg_i.position_duty;
    dly_sum  = '0;
    ramp_sum = '0;

    if (chn != '0) begin
      if (cfg_i.shared_mode == MODE_LB) s.lb_on = item_i.low_beam_request;
      if (cfg_i.shared_mode == MODE_POS) begin
        s.posn_duty = item_i.position_request ? pos_sat : 7'd0;
      end

      // ownership arbitration with one tick of history
      if (cfg_i.shared_mode == MODE_LB || cfg_i.shared_mode == MODE_POS) begin
        s.history[1:0] = {s_last, s_cur};
        if (cfg_i.shared_mode == MODE_LB) begin
          o_last = st_i.history[2];
          o_cur  = s.lb_on;
          s.history[3:2] = {o_last, o_cur};
        end else begin
          o_last = st_i.history[4];
          o_cur  = (s.posn_duty != 7'd0);
          s.history[5:4] = {o_last, o_cur};
        end
        priority if (o_cur)  s.owner = cfg_i.shared_mode;
        else if (s_cur)      s.owner = OWN_SELF;
        else if (o_last)     s.owner = cfg_i.shared_mode;
        else if (s_last)     s.owner = OWN_SELF;
      end else begin
        s.owner = OWN_SELF;
      end

      if (s.owner == OWN_SELF)     tactic = item_i.n1_strategy_bits[N1_SELF_BIT];
      else if (s.owner == OWN_POS) tactic = item_i.n1_strategy_bits[N1_POSN_BIT];

      // target by priority: position, low beam, self
      priority if (s.posn_duty != 7'd0)   s.cur_target = s.posn_duty;
      else if (s.lb_on)                   s.cur_target = DUTY_FULL;
      else                                s.cur_target = s_cur ? DUTY_FULL : 7'd0;

      if (prev_tgt == 7'd0 && s.cur_target != 7'd0) begin
        s.plain_mask  = chn ^ mtx;
        s.matrix_mask = mtx;
        s.phase       = PH_ON;
      end else if (prev_tgt != 7'd0 && s.cur_target == 7'd0) begin
        s.phase = PH_OFF;
      end

      // cut faulted channels, or all of them under N-1 or any derating flag
      if (s.cur_target != 7'd0 && cfg_i.high_side_channel == 2'd0) begin
        if (item_i.derate_flags != 5'd0) begin
          cut  = s.plain_mask | s.matrix_mask;
          skip = 1'b1;
        end else begin
          ep = s.plain_mask & item_i.stored_fault_channels;
          em = s.matrix_mask & item_i.stored_fault_channels;
          if (tactic && (ep | em) != '0) begin
            ep = s.plain_mask;
            em = s.matrix_mask;
          end
          s.plain_mask  = s.plain_mask ^ ep;
          s.matrix_mask = s.matrix_mask ^ em;
          cut = ep | em;
        end
      end

      if (!skip) begin
        unique case (s.phase)
          PH_ON: begin
            dly_sum = {1'b0, st_i.on_delay} + {1'b0, item_i.tick_time};
            s.on_delay = dly_sum[8] ? 8'hFF : dly_sum[7:0];
            if (s.on_delay >= delay_sel(cfg_i.delay_times, s.owner, 1'b0)) begin
              s.on_delay = 8'd0;
              s.phase    = PH_RUN;
            end
          end
          PH_OFF: begin
            dly_sum = {1'b0, st_i.off_delay} + {1'b0, item_i.tick_time};
            s.off_delay = dly_sum[8] ? 8'hFF : dly_sum[7:0];
            if (s.off_delay >= delay_sel(cfg_i.delay_times, s.owner, 1'b1)) begin
              s.off_delay = 8'd0;
              s.phase     = PH_RUN;
            end
          end
          default: begin
            upd = 1'b1;
            sw  = (cfg_i.high_side_channel != 2'd0) && (s.cur_target != 7'd0);
          end
        endcase
      end

      // on/off/error feedback, only while the lamp owns itself
      if (s.owner == OWN_SELF) begin
        if (item_i.lamp_request != st_i.req_last) begin
          s.on_ramp_cnt  = '0;
          s.off_ramp_cnt = '0;
        end else if (item_i.lamp_request) begin
          if (st_i.on_ramp_cnt < cfg_i.on_ramp_times[15:0]) begin
            ramp_sum = {1'b0, st_i.on_ramp_cnt} + {9'd0, item_i.tick_time};
            s.on_ramp_cnt = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
          end else if (cfg_i.high_side_channel != 2'd0) begin
            if (item_i.switch_error_state == HS_RUNTIME ||
                item_i.switch_error_state == HS_STORED) begin
              fb = FB_ERROR;
            end else if (item_i.switch_error_state == HS_NORMAL) begin
              fb = FB_ON;
            end
          end else begin
            err = (item_i.derate_flags[4:2] != 3'd0) ||
                  ((chn & item_i.live_fault_channels) != '0) ||
                  ((chn & item_i.sensor_fault_channels) != '0) ||
                  ((s.plain_mask | s.matrix_mask) != chn);
            fb = err ? FB_ERROR : FB_ON;
          end
        end else begin
          if (st_i.off_ramp_cnt < cfg_i.off_ramp_times[15:0]) begin
            ramp_sum = {1'b0, st_i.off_ramp_cnt} + {9'd0, item_i.tick_time};
            s.off_ramp_cnt = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
          end else begin
            fb = FB_OFF;
          end
        end
      end else begin
        fb = FB_OFF;
      end
      s.req_last = item_i.lamp_request;
    end
  end

  assign st_o = s;

  assign res_o.owner             = s.owner;
  assign res_o.target_duty       = s.cur_target;
  assign res_o.run_phase         = phase_code(s.phase);
  assign res_o.plain_drive_mask  = s.plain_mask;
  assign res_o.matrix_drive_mask = s.matrix_mask;
  assign res_o.cut_mask          = cut;
  assign res_o.drive_update      = upd;
  assign res_o.switch_on         = sw;
  assign res_o.on_ramp           = ramp_sel(cfg_i.on_ramp_times, s.owner);
  assign res_o.off_ramp          = ramp_sel(cfg_i.off_ramp_times, s.owner);
  assign res_o.feedback          = fb;

endmodule

// File: hdl/lamp_ownership_delay_fault_controller.sv
// Lamp ownership, delay and fault controller: top level with input and result registers.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one control tick: the lamp,
//    low beam and position requests, elapsed tick time, derating flags, fault
//    masks, N-1 strategy word and high-side switch error state.
//  - Output channel (out_valid_o / out_ready_i) returns one result per tick:
//    owner, target duty, run phase, drive and cut masks, drive update, switch
//    command, owner ramp times and feedback.
//  - Configuration writes (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//    are always taken; issue them only while no tick is in flight.
//  - Each tick is held in the input register, and its result is then
//    stored in the result register before it is offered on the output.
//  - Throughput: one tick per cycle while the receiver does not stall; the
//    per-tick update is a single pass of logic between the two registers.
//  - A stalled receiver holds the result register; one more tick may wait in
//    the input register, after which in_ready_o drops.
//  - Reset clears configuration, owner (self), history, targets, masks,
//    timers and counters, and sets the run phase.
module lamp_ownership_delay_fault_controller
  import lodfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                lamp_request_i,
  input  logic                low_beam_request_i,
  input  logic                position_request_i,
  input  logic [7:0]          tick_time_i,
  input  logic [4:0]          derate_flags_i,
  input  logic [Channels-1:0] stored_fault_channels_i,
  input  logic [Channels-1:0] live_fault_channels_i,
  input  logic [Channels-1:0] sensor_fault_channels_i,
  input  logic [15:0]         n1_strategy_bits_i,
  input  logic [1:0]          switch_error_state_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          owner_o,
  output logic [6:0]          target_duty_o,
  output logic [1:0]          run_phase_o,
  output logic [Channels-1:0] plain_drive_mask_o,
  output logic [Channels-1:0] matrix_drive_mask_o,
  output logic [Channels-1:0] cut_mask_o,
  output logic                drive_update_o,
  output logic                switch_on_o,
  output logic [15:0]         on_ramp_o,
  output logic [15:0]         off_ramp_o,
  output logic [1:0]          feedback_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  logic    out_vld_q;
  logic    advance;
  state_t  st_q, st_d;
  result_t res_d, res_q;

  lodfc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign cfg_ready_o = 1'b1;

  lodfc_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // move the held tick forward when the result register is free
  assign advance    = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.lamp_request          <= lamp_request_i;
      item_q.low_beam_request      <= low_beam_request_i;
      item_q.position_request      <= position_request_i;
      item_q.tick_time             <= tick_time_i;
      item_q.derate_flags          <= derate_flags_i;
      item_q.stored_fault_channels <= stored_fault_channels_i;
      item_q.live_fault_channels   <= live_fault_channels_i;
      item_q.sensor_fault_channels <= sensor_fault_channels_i;
      item_q.n1_strategy_bits      <= n1_strategy_bits_i;
      item_q.switch_error_state    <= switch_error_state_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.owner        <= OWN_SELF;
      st_q.history      <= '0;
      st_q.cur_target   <= '0;
      st_q.phase        <= PH_RUN;
      st_q.plain_mask   <= '0;
      st_q.matrix_mask  <= '0;
      st_q.on_delay     <= '0;
      st_q.off_delay    <= '0;
      st_q.req_last     <= 1'b0;
      st_q.on_ramp_cnt  <= '0;
      st_q.off_ramp_cnt <= '0;
      st_q.lb_on        <= 1'b0;
      st_q.posn_duty    <= '0;
      out_vld_q         <= 1'b0;
    end else begin
      if (advance) begin
        st_q      <= st_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign owner_o             = res_q.owner;
  assign target_duty_o       = res_q.target_duty;
  assign run_phase_o         = res_q.run_phase;
  assign plain_drive_mask_o  = res_q.plain_drive_mask;
  assign matrix_drive_mask_o = res_q.matrix_drive_mask;
  assign cut_mask_o          = res_q.cut_mask;
  assign drive_update_o      = res_q.drive_update;
  assign switch_on_o         = res_q.switch_on;
  assign on_ramp_o           = res_q.on_ramp;
  assign off_ramp_o          = res_q.off_ramp;
  assign feedback_o          = res_q.feedback;

endmodule

// File: verif/lamp_ownership_delay_fault_controller_tb.sv
// Self-checking testbench for the lamp ownership, delay and fault controller.
`timescale 1ns / 1ps

module lamp_ownership_delay_fault_controller_tb;
  import lodfc_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [1:0] HS_OTHER    = 2'd3;
  localparam logic [4:0] DERATE_HARD = 5'b11100;  // channel, LED, ambient overtemperature
  localparam int unsigned STUCK_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [47:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                lamp_request_i = 1'b0;
  logic                low_beam_request_i = 1'b0;
  logic                position_request_i = 1'b0;
  logic [7:0]          tick_time_i = '0;
  logic [4:0]          derate_flags_i = '0;
  logic [Channels-1:0] stored_fault_channels_i = '0;
  logic [Channels-1:0] live_fault_channels_i = '0;
  logic [Channels-1:0] sensor_fault_channels_i = '0;
  logic [15:0]         n1_strategy_bits_i = '0;
  logic [1:0]          switch_error_state_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          owner_o;
  logic [6:0]          target_duty_o;
  logic [1:0]          run_phase_o;
  logic [Channels-1:0] plain_drive_mask_o;
  logic [Channels-1:0] matrix_drive_mask_o;
  logic [Channels-1:0] cut_mask_o;
  logic                drive_update_o;
  logic                switch_on_o;
  logic [15:0]         on_ramp_o;
  logic [15:0]         off_ramp_o;
  logic [1:0]          feedback_o;

  lamp_ownership_delay_fault_controller dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .lamp_request_i          (lamp_request_i),
    .low_beam_request_i      (low_beam_request_i),
    .position_request_i      (position_request_i),
    .tick_time_i             (tick_time_i),
    .derate_flags_i          (derate_flags_i),
    .stored_fault_channels_i (stored_fault_channels_i),
    .live_fault_channels_i   (live_fault_channels_i),
    .sensor_fault_channels_i (sensor_fault_channels_i),
    .n1_strategy_bits_i      (n1_strategy_bits_i),
    .switch_error_state_i    (switch_error_state_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .owner_o                 (owner_o),
    .target_duty_o           (target_duty_o),
    .run_phase_o             (run_phase_o),
    .plain_drive_mask_o      (plain_drive_mask_o),
    .matrix_drive_mask_o     (matrix_drive_mask_o),
    .cut_mask_o              (cut_mask_o),
    .drive_update_o          (drive_update_o),
    .switch_on_o             (switch_on_o),
    .on_ramp_o               (on_ramp_o),
    .off_ramp_o              (off_ramp_o),
    .feedback_o              (feedback_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mirror of the configuration and of the controller state
  cfg_t        lamp_cfg = '0;
  logic [1:0]  own_q = OWN_SELF;
  logic [5:0]  hist_q = '0;
  logic [6:0]  prev_tgt_q = '0;
  logic [6:0]  tgt_q = '0;
  logic [1:0]  phase_q = RUN_CODE;
  logic [15:0] plain_q = '0;
  logic [15:0] matrix_q = '0;
  logic [7:0]  on_dly_q = '0;
  logic [7:0]  off_dly_q = '0;
  logic        req_q = 1'b0;
  logic [15:0] on_rmp_q = '0;
  logic [15:0] off_rmp_q = '0;
  logic [6:0]  lb_duty_q = '0;
  logic [6:0]  pos_duty_q = '0;

  result_t     pending_results[$];
  result_t     observed;
  int unsigned fail_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_off_len = 0;
  int unsigned sink_stall_pct = 0;

  function automatic result_t predict_tick(input item_t it);
    result_t     r;
    logic [15:0] chn, mtx, ep, em, cut;
    logic [6:0]  self_duty;
    logic [8:0]  dsum;
    logic [16:0] rsum;
    logic [1:0]  fb, other_own;
    logic        req_prev, tactic, upd, sw, skip, err;
    logic        s_last, s_cur, o_last, o_cur;
    int          sh;
    chn  = lamp_cfg.channel_mask;
    mtx  = lamp_cfg.matrix_mask;
    cut  = '0;
    upd  = 1'b0;
    sw   = 1'b0;
    skip = 1'b0;
    fb   = FB_HOLD;
    if (chn != '0) begin
      req_prev  = req_q;
      self_duty = it.lamp_request ? DUTY_FULL : 7'd0;
      if (lamp_cfg.shared_mode == MODE_LB)
        lb_duty_q = it.low_beam_request ? DUTY_FULL : 7'd0;
      if (lamp_cfg.shared_mode == MODE_POS)
        pos_duty_q = !it.position_request ? 7'd0 :
                     (lamp_cfg.position_duty > DUTY_FULL) ? DUTY_FULL : lamp_cfg.position_duty;

      // arbitrate ownership; the last active function keeps the lamp
      if (lamp_cfg.shared_mode == MODE_LB || lamp_cfg.shared_mode == MODE_POS) begin
        sh        = (lamp_cfg.shared_mode == MODE_LB) ? 2 : 4;
        other_own = (lamp_cfg.shared_mode == MODE_LB) ? OWN_LB : OWN_POS;
        s_last    = hist_q[0];
        s_cur     = self_duty != 7'd0;
        o_last    = hist_q[sh];
        o_cur     = ((lamp_cfg.shared_mode == MODE_LB) ? lb_duty_q : pos_duty_q) != 7'd0;
        hist_q[1:0]    = {s_last, s_cur};
        hist_q[sh]     = o_cur;
        hist_q[sh + 1] = o_last;
        if (o_cur) own_q = other_own;
        else if (s_cur) own_q = OWN_SELF;
        else if (o_last) own_q = other_own;
        else if (s_last) own_q = OWN_SELF;
      end else begin
        own_q = OWN_SELF;
      end
      tactic = (own_q == OWN_SELF) ? it.n1_strategy_bits[N1_SELF_BIT] :
               (own_q == OWN_POS) ? it.n1_strategy_bits[N1_POSN_BIT] : 1'b0;

      prev_tgt_q = tgt_q;
      tgt_q = (pos_duty_q != 7'd0) ? pos_duty_q : (lb_duty_q != 7'd0) ? lb_duty_q : self_duty;
      if (prev_tgt_q == 7'd0 && tgt_q != 7'd0) begin
        plain_q  = chn ^ mtx;
        matrix_q = mtx;
        phase_q  = ON_CODE;
      end else if (prev_tgt_q != 7'd0 && tgt_q == 7'd0) begin
        phase_q = OFF_CODE;
      end

      if (tgt_q != 7'd0 && lamp_cfg.high_side_channel == 2'd0) begin
        if (it.derate_flags != '0) begin
          cut  = plain_q | matrix_q;
          skip = 1'b1;
        end else begin
          ep = plain_q & it.stored_fault_channels;
          em = matrix_q & it.stored_fault_channels;
          // N-1 strategy: any fault drops every channel
          if (tactic && (ep | em) != '0) begin
            ep = plain_q;
            em = matrix_q;
          end
          plain_q  = plain_q ^ ep;
          matrix_q = matrix_q ^ em;
          cut      = ep | em;
        end
      end

      if (!skip) begin
        if (phase_q == ON_CODE) begin
          dsum     = {1'b0, on_dly_q} + it.tick_time;
          on_dly_q = dsum[8] ? 8'hFF : dsum[7:0];
          if (on_dly_q >= lamp_cfg.delay_times[16*own_q +: 8]) begin
            on_dly_q = '0;
            phase_q  = RUN_CODE;
          end
        end else if (phase_q == OFF_CODE) begin
          dsum      = {1'b0, off_dly_q} + it.tick_time;
          off_dly_q = dsum[8] ? 8'hFF : dsum[7:0];
          if (off_dly_q >= lamp_cfg.delay_times[16*own_q + 8 +: 8]) begin
            off_dly_q = '0;
            phase_q   = RUN_CODE;
          end
        end else begin
          upd = 1'b1;
          sw  = lamp_cfg.high_side_channel != 2'd0 && tgt_q != 7'd0;
        end
      end

      if (own_q == OWN_SELF) begin
        if (it.lamp_request != req_prev) begin
          on_rmp_q  = '0;
          off_rmp_q = '0;
        end else if (it.lamp_request) begin
          if (on_rmp_q < lamp_cfg.on_ramp_times[15:0]) begin
            rsum     = {1'b0, on_rmp_q} + it.tick_time;
            on_rmp_q = rsum[16] ? 16'hFFFF : rsum[15:0];
          end else if (lamp_cfg.high_side_channel != 2'd0) begin
            if (it.switch_error_state == HS_RUNTIME || it.switch_error_state == HS_STORED)
              fb = FB_ERROR;
            else if (it.switch_error_state == HS_NORMAL)
              fb = FB_ON;
          end else begin
            err = (it.derate_flags & DERATE_HARD) != '0 ||
                  (chn & it.live_fault_channels) != '0 ||
                  (chn & it.sensor_fault_channels) != '0 ||
                  (plain_q | matrix_q) != chn;
            fb = err ? FB_ERROR : FB_ON;
          end
        end else begin
          if (off_rmp_q < lamp_cfg.off_ramp_times[15:0]) begin
            rsum      = {1'b0, off_rmp_q} + it.tick_time;
            off_rmp_q = rsum[16] ? 16'hFFFF : rsum[15:0];
          end else begin
            fb = FB_OFF;
          end
        end
      end else begin
        fb = FB_OFF;
      end
      req_q = it.lamp_request;
    end

    r.owner             = own_q;
    r.target_duty       = tgt_q;
    r.run_phase         = phase_q;
    r.plain_drive_mask  = plain_q;
    r.matrix_drive_mask = matrix_q;
    r.cut_mask          = cut;
    r.drive_update      = upd;
    r.switch_on         = sw;
    r.on_ramp           = lamp_cfg.on_ramp_times[16*own_q +: 16];
    r.off_ramp          = lamp_cfg.off_ramp_times[16*own_q +: 16];
    r.feedback          = fb;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t noise_tick();
    item_t it;
    it.lamp_request          = 1'($urandom_range(0, 1));
    it.low_beam_request      = 1'($urandom_range(0, 1));
    it.position_request      = 1'($urandom_range(0, 1));
    it.tick_time             = 8'($urandom);
    it.derate_flags          = 5'($urandom);
    it.stored_fault_channels = 16'($urandom);
    it.live_fault_channels   = 16'($urandom);
    it.sensor_fault_channels = 16'($urandom);
    it.n1_strategy_bits      = 16'($urandom);
    it.switch_error_state    = 2'($urandom);
    return it;
  endfunction

  // sparse faults and short ticks so that lamps actually run and ramp
  function automatic item_t shaped_tick(input logic lamp, input logic lb, input logic pos);
    item_t it;
    it = noise_tick();
    it.lamp_request     = lamp;
    it.low_beam_request = lb;
    it.position_request = pos;
    it.tick_time = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(100, 255)) :
                                                 8'($urandom_range(0, 12));
    it.derate_flags = ($urandom_range(0, 9) == 0) ? 5'(1 << $urandom_range(0, 4)) : 5'd0;
    it.stored_fault_channels =
      ($urandom_range(0, 7) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'd0;
    it.live_fault_channels =
      ($urandom_range(0, 5) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'd0;
    it.sensor_fault_channels =
      ($urandom_range(0, 5) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'd0;
    return it;
  endfunction

  function automatic item_t quiet_tick(input logic lamp, input logic lb, input logic pos,
                                       input logic [7:0] tick);
    item_t it;
    it = '0;
    it.lamp_request     = lamp;
    it.low_beam_request = lb;
    it.position_request = pos;
    it.tick_time        = tick;
    return it;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.shared_mode       = 2'($urandom_range(0, 3));
    c.high_side_channel = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
    c.position_duty     = 7'($urandom_range(0, 127));
    case ($urandom_range(0, 5))
      0:       c.channel_mask = 16'hFFFF;
      1:       c.channel_mask = 16'h0000;
      default: c.channel_mask = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 4))
      0:       c.matrix_mask = 16'h0000;
      1:       c.matrix_mask = 16'hFFFF;
      default: c.matrix_mask = 16'($urandom);
    endcase
    for (int k = 0; k < 6; k++)
      c.delay_times[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 20));
    for (int k = 0; k < 3; k++) begin
      c.on_ramp_times[16*k +: 16] =
        ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30));
      c.off_ramp_times[16*k +: 16] =
        ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30));
    end
    return c;
  endfunction

  task automatic send_tick(input item_t it, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    lamp_request_i          <= it.lamp_request;
    low_beam_request_i      <= it.low_beam_request;
    position_request_i      <= it.position_request;
    tick_time_i             <= it.tick_time;
    derate_flags_i          <= it.derate_flags;
    stored_fault_channels_i <= it.stored_fault_channels;
    live_fault_channels_i   <= it.live_fault_channels;
    sensor_fault_channels_i <= it.sensor_fault_channels;
    n1_strategy_bits_i      <= it.n1_strategy_bits;
    switch_error_state_i    <= it.switch_error_state;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_tick(it));
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] reg_index, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (reg_index)
      CFG_SHARED_MODE:   lamp_cfg.shared_mode       = data[1:0];
      CFG_HIGH_SIDE:     lamp_cfg.high_side_channel = data[1:0];
      CFG_POSITION_DUTY: lamp_cfg.position_duty     = data[6:0];
      CFG_CHANNEL_MASK:  lamp_cfg.channel_mask      = data[15:0];
      CFG_MATRIX_MASK:   lamp_cfg.matrix_mask       = data[15:0];
      CFG_DELAY_TIMES:   lamp_cfg.delay_times       = data;
      CFG_ON_RAMPS:      lamp_cfg.on_ramp_times     = data;
      CFG_OFF_RAMPS:     lamp_cfg.off_ramp_times    = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    settle();
    write_reg(CFG_SHARED_MODE, 48'(c.shared_mode));
    write_reg(CFG_HIGH_SIDE, 48'(c.high_side_channel));
    write_reg(CFG_POSITION_DUTY, 48'(c.position_duty));
    write_reg(CFG_CHANNEL_MASK, 48'(c.channel_mask));
    write_reg(CFG_MATRIX_MASK, 48'(c.matrix_mask));
    write_reg(CFG_DELAY_TIMES, c.delay_times);
    write_reg(CFG_ON_RAMPS, c.on_ramp_times);
    write_reg(CFG_OFF_RAMPS, c.off_ramp_times);
    cfg_valid_i <= 1'b0;
  endtask

  // request patterns held for a few ticks, with some noise mixed in
  task automatic run_sequences(input int unsigned count);
    int unsigned sent, len;
    logic        lamp, lb, pos;
    bit          quiet;
    item_t       it;
    sent = 0;
    while (sent < count) begin
      quiet = ($urandom_range(0, 3) == 0);
      lamp  = 1'($urandom_range(0, 1));
      lb    = ($urandom_range(0, 2) == 0);
      pos   = ($urandom_range(0, 2) == 0);
      len   = $urandom_range(2, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 11) == 0) it = noise_tick();
        else it = shaped_tick(lamp, lb, pos);
        send_tick(it, quiet ? 0 : draw_gap());
      end
      sent += len;
    end
  endtask

  task automatic test_idle_block();
    item_t it;
    apply_settings('0);
    sink_stall_pct = 20;
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd0), 0);
    it = '1;
    send_tick(it, 0);
  endtask

  task automatic test_standalone_lamp();
    cfg_t  c;
    item_t it;
    c = '0;
    c.shared_mode    = MODE_ALONE;
    c.channel_mask   = 16'hFFFF;
    c.matrix_mask    = 16'h00FF;
    c.delay_times    = 48'h0000_0000_0203;
    c.on_ramp_times  = 48'd4;
    c.off_ramp_times = 48'd4;
    apply_settings(c);
    sink_stall_pct = 0;
    send_tick(quiet_tick(1'b1, 1'b0, 1'b0, 8'd0), 0);
    send_tick(quiet_tick(1'b1, 1'b0, 1'b0, 8'd255), 0);
    send_tick(quiet_tick(1'b1, 1'b0, 1'b0, 8'd5), 0);
    send_tick(quiet_tick(1'b1, 1'b0, 1'b0, 8'd5), 0);
    it = quiet_tick(1'b1, 1'b0, 1'b0, 8'd1);
    it.derate_flags = 5'h1F;
    send_tick(it, 0);
    it = quiet_tick(1'b1, 1'b0, 1'b0, 8'd1);
    it.live_fault_channels   = 16'hFFFF;
    it.sensor_fault_channels = 16'hFFFF;
    it.switch_error_state    = HS_OTHER;
    send_tick(it, 1);
    it = quiet_tick(1'b1, 1'b0, 1'b0, 8'd1);
    it.stored_fault_channels = 16'h0001;
    send_tick(it, 0);
    it.stored_fault_channels = 16'h0100;
    it.n1_strategy_bits      = 16'hFFFF;
    send_tick(it, 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd255), 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd0), 2);
  endtask

  task automatic test_shared_owners();
    cfg_t  c;
    item_t it;
    c = '0;
    c.shared_mode    = MODE_LB;
    c.channel_mask   = 16'h0F0F;
    c.matrix_mask    = 16'hFF00;
    c.delay_times    = 48'h0101_0101_0101;
    c.on_ramp_times  = 48'hFFFF_0002_0001;
    c.off_ramp_times = 48'h0003_FFFF_0001;
    apply_settings(c);
    send_tick(quiet_tick(1'b0, 1'b1, 1'b0, 8'd3), 0);
    send_tick(quiet_tick(1'b1, 1'b0, 1'b0, 8'd3), 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd3), 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd3), 0);
    // position duty above full scale saturates
    c.shared_mode   = MODE_POS;
    c.position_duty = 7'd127;
    apply_settings(c);
    it = quiet_tick(1'b0, 1'b0, 1'b1, 8'd2);
    it.n1_strategy_bits      = 16'h0020;
    it.stored_fault_channels = 16'h0100;
    send_tick(it, 0);
    send_tick(quiet_tick(1'b1, 1'b0, 1'b1, 8'd2), 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd2), 0);
    send_tick(quiet_tick(1'b0, 1'b0, 1'b0, 8'd2), 0);
  endtask

  task automatic test_high_side_switch();
    cfg_t  c;
    item_t it;
    c = '0;
    c.shared_mode       = MODE_SPARE;
    c.high_side_channel = 2'd3;
    c.channel_mask      = 16'h8001;
    apply_settings(c);
    it = quiet_tick(1'b1, 1'b1, 1'b1, 8'd1);
    it.switch_error_state = HS_NORMAL;
    send_tick(it, 0);
    it.switch_error_state = HS_RUNTIME;
    send_tick(it, 0);
    it.switch_error_state = HS_STORED;
    send_tick(it, 0);
    it.switch_error_state = HS_OTHER;
    send_tick(it, 0);
  endtask

  // hold the result side for a long time while ticks keep coming
  task automatic test_result_backpressure();
    cfg_t c;
    c = random_settings();
    c.channel_mask = 16'hFFFF;
    apply_settings(c);
    sink_stall_pct = 0;
    hold_off_len   = 300;
    repeat (20) send_tick(shaped_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0), 0);
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int p = 0; p < 8; p++) begin
      c = random_settings();
      if (p == 0) begin
        c.channel_mask      = '1;
        c.matrix_mask       = '1;
        c.position_duty     = '1;
        c.delay_times       = '1;
        c.on_ramp_times     = '1;
        c.off_ramp_times    = '1;
        c.high_side_channel = 2'd0;
      end else if (p == 1) begin
        c.channel_mask   = 16'h0001;
        c.matrix_mask    = '0;
        c.delay_times    = '0;
        c.on_ramp_times  = '0;
        c.off_ramp_times = '0;
      end
      apply_settings(c);
      sink_stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 40;
      run_sequences(48);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none got %h", $time, got);
    end else begin
      want = pending_results.pop_front();
      compare_field("owner", 16'(want.owner), 16'(got.owner));
      compare_field("target_duty", 16'(want.target_duty), 16'(got.target_duty));
      compare_field("run_phase", 16'(want.run_phase), 16'(got.run_phase));
      compare_field("plain_drive_mask", want.plain_drive_mask, got.plain_drive_mask);
      compare_field("matrix_drive_mask", want.matrix_drive_mask, got.matrix_drive_mask);
      compare_field("cut_mask", want.cut_mask, got.cut_mask);
      compare_field("drive_update", 16'(want.drive_update), 16'(got.drive_update));
      compare_field("switch_on", 16'(want.switch_on), 16'(got.switch_on));
      compare_field("on_ramp", want.on_ramp, got.on_ramp);
      compare_field("off_ramp", want.off_ramp, got.off_ramp);
      compare_field("feedback", 16'(want.feedback), 16'(got.feedback));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed = {owner_o, target_duty_o, run_phase_o, plain_drive_mask_o,
                  matrix_drive_mask_o, cut_mask_o, drive_update_o, switch_on_o,
                  on_ramp_o, off_ramp_o, feedback_o};
      check_result(observed);
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat (draw_gap()) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_block();
    test_standalone_lamp();
    test_shared_owners();
    test_high_side_switch();
    test_result_backpressure();
    test_random_phases();
    settle();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t: pending results expected 0 got %0d", $time, pending_results.size());
    end
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
hdl/lodfc_pkg.sv
hdl/lodfc_cfg.sv
hdl/lodfc_step.sv
hdl/lamp_ownership_delay_fault_controller.sv
verif/lamp_ownership_delay_fault_controller_tb.sv
